// ===== src/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Trefoil surface evaluator package
// Shared types, constants and the arctangent table for the CORDIC chain.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Fixed-point format of registers, angles and results.
  localparam int FracBits  = 12;
  localparam int RegW      = 16;
  localparam int OutW      = 18;
  localparam int NumOut    = 9;
  localparam int NumSteps  = 30;

  // Configuration register indexes.
  localparam logic [1:0] RegMajorRadius = 2'd0;
  localparam logic [1:0] RegTubeRadius  = 2'd1;

  // Angle constants in Q30.
  localparam logic [35:0]        TwoPiU   = 36'd6746518852;
  localparam logic [35:0]        PiU      = 36'd3373259426;
  localparam logic signed [34:0] PiS      = 35'sd3373259426;
  localparam logic signed [34:0] TwoPiS   = 35'sd6746518852;
  localparam logic signed [34:0] HalfPiS  = 35'sd1686629713;
  localparam logic signed [32:0] CordicK  = 33'sd652032874;

  // One CORDIC lane: rotation vector, residual angle and the fold flag.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               neg;
  } tsp_lane_t;

  // Lane order: u/3, u/2, v - pi, v.
  typedef tsp_lane_t [3:0] tsp_lanes_t;

  typedef logic signed [OutW-1:0] tsp_res_t;
  typedef tsp_res_t [NumOut-1:0] tsp_results_t;

  // Arctangent of 2^-step in Q30.
  function automatic logic [29:0] atan_q30(input logic [4:0] step);
    logic [29:0] val;
    case (step)
      5'd0:    val = 30'd843314857;
      5'd1:    val = 30'd497837829;
      5'd2:    val = 30'd263043837;
      5'd3:    val = 30'd133525159;
      5'd4:    val = 30'd67021687;
      5'd5:    val = 30'd33543516;
      5'd6:    val = 30'd16775851;
      5'd7:    val = 30'd8388437;
      5'd8:    val = 30'd4194283;
      5'd9:    val = 30'd2097149;
      5'd10:   val = 30'd1048576;
      5'd11:   val = 30'd524288;
      5'd12:   val = 30'd262144;
      5'd13:   val = 30'd131072;
      5'd14:   val = 30'd65536;
      5'd15:   val = 30'd32768;
      5'd16:   val = 30'd16384;
      5'd17:   val = 30'd8192;
      5'd18:   val = 30'd4096;
      5'd19:   val = 30'd2048;
      5'd20:   val = 30'd1024;
      5'd21:   val = 30'd512;
      5'd22:   val = 30'd256;
      5'd23:   val = 30'd128;
      5'd24:   val = 30'd64;
      5'd25:   val = 30'd32;
      5'd26:   val = 30'd16;
      5'd27:   val = 30'd8;
      5'd28:   val = 30'd4;
      5'd29:   val = 30'd2;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/trefoil_surface_point_eval.sv =====
// ----------------------------------------------------------------------------
// Trefoil knot tube surface evaluator
// Point and partial derivatives of a trefoil tube surface for one (u, v) pair.
//
//   Channel   Direction  Payload
//   s_axis    in         u_angle, v_angle
//   m_axis    out        pos_x/y/z, du_x/y/z, dv_x/y/z
//   cfg       in         major_radius (index 0), tube_radius (index 1)
//
// One item per cycle is taken while the pipeline advances; each item passes through
// 6 angle preparation stages, 30 CORDIC cells and 6 arithmetic stages.
// The whole pipeline advances together and holds while a result waits.
// Reset leaves the pipeline empty and loads R = 1.5 and r = 0.5.
// ----------------------------------------------------------------------------
module trefoil_surface_point_eval (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // u_angle [17:0], v_angle [32:18], zero fill [39:33]
  input  logic [39:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x, pos_y, pos_z, du_x, du_y, du_z, dv_x, dv_y, dv_z, 18 bits each,
  // zero fill [167:162]
  output logic [167:0]  m_axis_tdata
);
  import tsp_pkg::*;

  logic signed [15:0] major_radius_q, tube_radius_q;
  logic               en;
  logic               prep_vld;
  tsp_lanes_t         prep_lanes;
  logic               chain_vld   [NumSteps+1];
  tsp_lanes_t         chain_lanes [NumSteps+1];
  tsp_results_t       results;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_radius_q <= 16'sd6144;
      tube_radius_q  <= 16'sd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMajorRadius: major_radius_q <= $signed(cfg_wdata_i);
        RegTubeRadius:  tube_radius_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output slot is free or being taken.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tsp_angle_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .u_angle_i (s_axis_tdata[17:0]),
    .v_angle_i (s_axis_tdata[32:18]),
    .valid_o   (prep_vld),
    .lanes_o   (prep_lanes)
  );

  assign chain_vld[0]   = prep_vld;
  assign chain_lanes[0] = prep_lanes;

  // CORDIC chain, one cell per rotation step.
  for (genvar g = 0; g < NumSteps; g++) begin : g_cell
    tsp_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (5'(g)),
      .valid_i (chain_vld[g]),
      .lanes_i (chain_lanes[g]),
      .valid_o (chain_vld[g+1]),
      .lanes_o (chain_lanes[g+1])
    );
  end

  tsp_surface_math u_math (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (chain_vld[NumSteps]),
    .lanes_i        (chain_lanes[NumSteps]),
    .major_radius_i (major_radius_q),
    .tube_radius_i  (tube_radius_q),
    .valid_o        (m_axis_tvalid),
    .results_o      (results)
  );

  assign m_axis_tdata = {6'd0, results};

endmodule

// ===== src/tsp_angle_prep.sv =====
// ----------------------------------------------------------------------------
// Angle preparation
// Forms u/3, u/2, v - pi and v in Q30, reduces them into one period and
// folds them into [-pi/2, pi/2] as the start of each CORDIC lane.
// ----------------------------------------------------------------------------
module tsp_angle_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [17:0]         u_angle_i,
  input  logic [14:0]         v_angle_i,
  output logic                valid_o,
  output tsp_pkg::tsp_lanes_t lanes_o
);
  import tsp_pkg::*;

  logic [5:0]  vld_q;
  logic [35:0] umul_q;
  logic [17:0] u_q;
  logic [14:0] v_q;
  logic [35:0] ang_q [4][4];
  logic [35:0] ang_d [4];
  logic [35:0] red_d [3][4];
  tsp_lanes_t  lanes_q, lanes_d;

  // Multiples of two pi used by the three reduction steps.
  logic [35:0] red_k [3];
  assign red_k[0] = 36'd26986075408;
  assign red_k[1] = 36'd13493037704;
  assign red_k[2] = TwoPiU;

  // Split u into 3a + b and build the four Q30 angles.
  always_comb begin
    logic [16:0] a3;
    logic [17:0] three_a;
    logic [1:0]  rem;
    logic [17:0] frac;
    a3      = umul_q[35:19];
    three_a = 18'({a3, 1'b0}) + 18'(a3);
    rem     = 2'(u_q - three_a);
    case (rem)
      2'd1:    frac = 18'd87381;
      2'd2:    frac = 18'd174762;
      default: frac = 18'd0;
    endcase
    ang_d[0] = 36'({a3, 18'd0}) + 36'(frac);
    ang_d[1] = 36'({u_q, 17'd0});
    ang_d[2] = 36'({v_q, 18'd0}) + PiU;
    ang_d[3] = 36'({v_q, 18'd0});
  end

  // One conditional subtract of a multiple of two pi per stage.
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int l = 0; l < 4; l++) begin
        red_d[s][l] = (ang_q[s][l] >= red_k[s]) ? ang_q[s][l] - red_k[s] : ang_q[s][l];
      end
    end
  end

  // Shift into [-pi, pi) and fold beyond a quarter turn.
  always_comb begin
    logic signed [34:0] zf;
    for (int l = 0; l < 4; l++) begin
      zf = $signed({2'b00, ang_q[3][l][32:0]});
      if (zf >= PiS) begin
        zf = zf - TwoPiS;
      end
      lanes_d[l].neg = 1'b0;
      if (zf > HalfPiS) begin
        zf = zf - PiS;
        lanes_d[l].neg = 1'b1;
      end else if (zf < -HalfPiS) begin
        zf = zf + PiS;
        lanes_d[l].neg = 1'b1;
      end
      lanes_d[l].x = CordicK;
      lanes_d[l].y = '0;
      lanes_d[l].z = zf[32:0];
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      umul_q <= 36'(u_angle_i) * 36'd174763;
      u_q    <= u_angle_i;
      v_q    <= v_angle_i;
      for (int l = 0; l < 4; l++) begin
        ang_q[0][l] <= ang_d[l];
        for (int s = 0; s < 3; s++) begin
          ang_q[s+1][l] <= red_d[s][l];
        end
      end
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = vld_q[5];
  assign lanes_o = lanes_q;

endmodule

// ===== src/tsp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step for the four angle lanes; cells are chained, one per step.
// ----------------------------------------------------------------------------
module tsp_cordic_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [4:0]          step_i,
  input  logic                valid_i,
  input  tsp_pkg::tsp_lanes_t lanes_i,
  output logic                valid_o,
  output tsp_pkg::tsp_lanes_t lanes_o
);
  import tsp_pkg::*;

  logic       valid_q;
  tsp_lanes_t lanes_q, lanes_d;

  // Rotate toward zero residual angle.
  always_comb begin
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic signed [32:0] at;
    at = $signed({3'b000, atan_q30(step_i)});
    for (int l = 0; l < 4; l++) begin
      sx = lanes_i[l].x >>> step_i;
      sy = lanes_i[l].y >>> step_i;
      lanes_d[l].neg = lanes_i[l].neg;
      if (!lanes_i[l].z[32]) begin
        lanes_d[l].x = lanes_i[l].x - sy;
        lanes_d[l].y = lanes_i[l].y + sx;
        lanes_d[l].z = lanes_i[l].z - at;
      end else begin
        lanes_d[l].x = lanes_i[l].x + sy;
        lanes_d[l].y = lanes_i[l].y - sx;
        lanes_d[l].z = lanes_i[l].z + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

// ===== src/tsp_surface_math.sv =====
// ----------------------------------------------------------------------------
// Surface arithmetic
// Rounds the CORDIC results to Q16, forms the point and both derivatives,
// and scales them to the output format with rounding and saturation.
// ----------------------------------------------------------------------------
module tsp_surface_math (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  tsp_pkg::tsp_lanes_t   lanes_i,
  input  logic signed [15:0]    major_radius_i,
  input  logic signed [15:0]    tube_radius_i,
  output logic                  valid_o,
  output tsp_pkg::tsp_results_t results_o
);
  import tsp_pkg::*;

  logic [5:0] vld_q;

  // Stage 0: rounded sine and cosine per lane.
  logic signed [17:0] s_q [4];
  logic signed [17:0] c_q [4];
  logic signed [17:0] s_d [4];
  logic signed [17:0] c_d [4];

  always_comb begin
    logic signed [32:0] xr;
    logic signed [32:0] yr;
    for (int l = 0; l < 4; l++) begin
      xr = (lanes_i[l].x + 33'sd8192) >>> 14;
      yr = (lanes_i[l].y + 33'sd8192) >>> 14;
      c_d[l] = lanes_i[l].neg ? -xr[17:0] : xr[17:0];
      s_d[l] = lanes_i[l].neg ? -yr[17:0] : yr[17:0];
    end
  end

  // Stage 1: tube radius products.
  logic signed [17:0] su3_1_q, cu3_1_q, su2_1_q, cu2_1_q;
  logic signed [33:0] rcu2_q, rcvm_q, rsvm_q, rcv_q, rsu2_q, rsv_q;

  // Stage 2: bracketed sums and the terms that need no further product.
  logic signed [17:0] su3_2_q, cu3_2_q;
  logic signed [35:0] a_q, b_q, t_q;
  logic signed [33:0] p_q;
  logic signed [55:0] nz_2_q, nduz_2_q, ndvz_2_q;

  // Stage 3: products with the u/3 trig values.
  logic signed [53:0] acu3_q, asu3_q, bsu3_q, bcu3_q, tcu3_q, tsu3_q, pcu3_q, psu3_q;
  logic signed [55:0] nz_3_q, nduz_3_q, ndvz_3_q;

  // Stage 4: scaled numerators reduced by 2^32 with the half-step offset.
  logic signed [55:0] n_d [NumOut];
  logic signed [23:0] m_q [NumOut];

  always_comb begin
    logic signed [55:0] e_acu3, e_asu3, e_pcu3, e_psu3;
    e_acu3 = 56'(acu3_q);
    e_asu3 = 56'(asu3_q);
    e_pcu3 = 56'(pcu3_q);
    e_psu3 = 56'(psu3_q);
    n_d[0] = (e_acu3 <<< 2) + (e_acu3 <<< 1);
    n_d[1] = (e_asu3 <<< 2) + (e_asu3 <<< 1);
    n_d[2] = nz_3_q;
    n_d[3] = -56'(bsu3_q) - 56'(tcu3_q);
    n_d[4] = 56'(bcu3_q) - 56'(tsu3_q);
    n_d[5] = nduz_3_q;
    n_d[6] = (e_pcu3 <<< 2) + (e_pcu3 <<< 1);
    n_d[7] = (e_psu3 <<< 2) + (e_psu3 <<< 1);
    n_d[8] = ndvz_3_q;
  end

  // Stage 5: floor divide by six with saturation.
  tsp_results_t res_q, res_d;

  always_comb begin
    logic signed [22:0] m2;
    logic [19:0]        nn;
    logic [39:0]        prod;
    for (int k = 0; k < NumOut; k++) begin
      m2   = 23'(m_q[k] >>> 1);
      nn   = 20'(m2 + 23'sd393216);
      prod = 40'(nn) * 40'd699051;
      if (m_q[k] >= 24'sd786432) begin
        res_d[k] = 18'sd131071;
      end else if (m_q[k] < -24'sd786432) begin
        res_d[k] = -18'sd131072;
      end else begin
        res_d[k] = 18'(prod[39:21]) - 18'sd131072;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 0.
      for (int l = 0; l < 4; l++) begin
        s_q[l] <= s_d[l];
        c_q[l] <= c_d[l];
      end
      // Stage 1.
      su3_1_q <= s_q[0];
      cu3_1_q <= c_q[0];
      su2_1_q <= s_q[1];
      cu2_1_q <= c_q[1];
      rcu2_q  <= tube_radius_i * c_q[1];
      rcvm_q  <= tube_radius_i * c_q[2];
      rsvm_q  <= tube_radius_i * s_q[2];
      rcv_q   <= tube_radius_i * c_q[3];
      rsu2_q  <= tube_radius_i * s_q[1];
      rsv_q   <= tube_radius_i * s_q[3];
      // Stage 2.
      su3_2_q  <= su3_1_q;
      cu3_2_q  <= cu3_1_q;
      a_q      <= (36'(major_radius_i) <<< 16) + 36'(rcu2_q) + 36'(rcvm_q);
      b_q      <= ((36'(major_radius_i) <<< 16) + 36'(rcu2_q) - 36'(rcv_q)) <<< 1;
      t_q      <= (36'(rsu2_q) <<< 1) + 36'(rsu2_q);
      p_q      <= rsv_q;
      nz_2_q   <= 56'(((56'(tube_radius_i) <<< 32) + (56'(su2_1_q) <<< 28)
                      + (56'(rsvm_q) <<< 16)) * 56'sd6);
      nduz_2_q <= (56'(cu2_1_q) <<< 29) + (56'(cu2_1_q) <<< 28);
      ndvz_2_q <= 56'((56'(rcv_q) <<< 16) * -56'sd6);
      // Stage 3.
      acu3_q   <= a_q * cu3_2_q;
      asu3_q   <= a_q * su3_2_q;
      bsu3_q   <= b_q * su3_2_q;
      bcu3_q   <= b_q * cu3_2_q;
      tcu3_q   <= t_q * cu3_2_q;
      tsu3_q   <= t_q * su3_2_q;
      pcu3_q   <= 54'(p_q) * 54'(cu3_2_q);
      psu3_q   <= 54'(p_q) * 54'(su3_2_q);
      nz_3_q   <= nz_2_q;
      nduz_3_q <= nduz_2_q;
      ndvz_3_q <= ndvz_2_q;
      // Stage 4.
      for (int k = 0; k < NumOut; k++) begin
        m_q[k] <= 24'((n_d[k] + 56'sd12884901888) >>> 32);
      end
      // Stage 5.
      res_q <= res_d;
    end
  end

  assign valid_o   = vld_q[5];
  assign results_o = res_q;

endmodule
